// ===== hw/rtl/keyed_energy_weighted_time_table_macros.svh =====
// Assertion macros for the keyed energy-weighted time table.
`ifndef KEYED_ENERGY_WEIGHTED_TIME_TABLE_MACROS_SVH
`define KEYED_ENERGY_WEIGHTED_TIME_TABLE_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define KEWT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked during reset as well.
`define KEWT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/kewt_pkg.sv =====
// Package: widths, constants and result type of the keyed energy-weighted time table.
package kewt_pkg;
  localparam int TableDepthDefault = 16;
  localparam logic [31:0] TimeMax = 32'h7FFF_FFFF;
  localparam logic [31:0] Sat32 = 32'hFFFF_FFFF;
  localparam logic ActAdd = 1'b0;
  localparam logic ActClear = 1'b1;

  typedef struct packed {
    logic              action;
    logic [31:0]       particle_id;
    logic signed [31:0] particle_type;
    logic [23:0]       energy;
    logic signed [31:0] hit_time;
  } dep_t;

  typedef struct packed {
    logic [3:0]        entry_index;
    logic              was_new;
    logic              overflow;
    logic [31:0]       entry_energy;
    logic signed [31:0] entry_time;
    logic [4:0]        entry_count;
    logic signed [31:0] first_time;
    logic signed [31:0] mean_time;
    logic [31:0]       total_energy;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [23:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[32] ? Sat32 : s[31:0];
  endfunction
endpackage

// ===== hw/rtl/kewt_if.sv =====
// Valid/ready channel interfaces for deposits and results.
interface kewt_dep_if;
  import kewt_pkg::*;
  logic valid;
  logic ready;
  dep_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kewt_res_if;
  import kewt_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/keyed_energy_weighted_time_table.sv =====
// Top level of the keyed energy-weighted time table.
//  channel | dir | payload | transaction
//  dep     | in  | dep_t   | one deposit or clear
//  res     | out | res_t   | one result per deposit
// A deposit reads the table one slot per cycle, then runs up to two serial
// divisions (one on a miss, two on a hit); a hit in the last slot is slowest.
// A clear answers in the next cycle.
// Reset empties the table through the fill count.
// The next deposit is held off until the cycle after the result is taken.
module keyed_energy_weighted_time_table #(
  parameter int TABLE_DEPTH = kewt_pkg::TableDepthDefault
) (
  input logic clk,
  input logic rst,
  kewt_dep_if.sink dep,
  kewt_res_if.source res
);
  import kewt_pkg::*;
  `include "keyed_energy_weighted_time_table_macros.svh"

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DIV1 = 3'd2,
                         S_DIV2 = 3'd3, S_OUT = 3'd4;

  // one memory holds all four stores, entries packed as {key, type, energy, time}
  logic [127:0] mem [TABLE_DEPTH];
  logic [127:0] rd;
  logic [IdxW-1:0] raddr;
  logic         we;
  logic [IdxW-1:0] waddr;
  logic [127:0] wdata;

  logic [2:0]  state;
  dep_t        cur;
  logic [CntW-1:0] used;
  logic [31:0] sum_e, wmean, earliest;
  logic [CntW-1:0] scan;
  logic        rd_pend;
  logic        hit;
  logic [IdxW-1:0] slot;
  logic [31:0] ent_e_old, ent_t_old, ent_type_old;
  logic        b_start, b_done;
  logic [31:0] b_mean, b_w, b_res;
  logic [31:0] ent_t_new;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  kewt_blend u_blend (
    .clk, .rst, .start(b_start), .mean(b_mean), .weight(b_w),
    .t(cur.hit_time), .e(cur.energy), .done(b_done), .result(b_res)
  );

  assign raddr = scan[IdxW-1:0];
  assign dep.ready = (state == S_IDLE) && !res.valid;
  // the entry update starts in the first S_DIV1 cycle, the total update in S_DIV2
  assign b_mean = (state == S_DIV1) ? ent_t_old : wmean;
  assign b_w = (state == S_DIV1) ? ent_e_old : sum_e;

  logic scan_end, scan_hit;
  assign scan_hit = rd_pend && (rd[127:96] == cur.particle_id);
  assign scan_end = !rd_pend && (scan >= used);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used <= '0;
      sum_e <= '0;
      wmean <= '0;
      earliest <= TimeMax;
      res.valid <= 1'b0;
      b_start <= 1'b0;
      we <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      b_start <= ((state == S_SCAN) && (scan_hit || scan_end)) ||
                 ((state == S_DIV1) && b_done);
      we <= (state == S_OUT) && (hit || (used < CntW'(TABLE_DEPTH)));
      if (res.valid && res.ready) res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          res_t cr;
          if (dep.valid && dep.ready) begin
            cur <= dep.data;
            scan <= '0;
            rd_pend <= 1'b0;
            hit <= 1'b0;
            if (dep.data.action == ActClear) begin
              used <= '0;
              sum_e <= '0;
              wmean <= '0;
              earliest <= TimeMax;
              cr = '0;
              cr.first_time = TimeMax;
              res.data <= cr;
              res.valid <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit <= 1'b1;
            slot <= IdxW'(scan - CntW'(1));
            ent_e_old <= rd[63:32];
            ent_t_old <= rd[31:0];
            ent_type_old <= rd[95:64];
            state <= S_DIV1;
          end else if (scan_end) begin
            hit <= 1'b0;
            slot <= used[IdxW-1:0];
            state <= S_DIV2;
          end else if (rd_pend || scan < used) begin
            rd_pend <= (scan < used);
            if (scan < used) scan <= scan + CntW'(1);
          end
        end
        S_DIV1: begin
          if (b_done) begin
            ent_t_new <= b_res;
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (b_done) begin
            wmean <= b_res;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          logic [31:0] ne;
          logic [31:0] new_sum;
          logic [31:0] new_first;
          res_t r;
          ne = sat_add(ent_e_old, cur.energy);
          new_sum = sat_add(sum_e, cur.energy);
          new_first = ($signed(cur.hit_time) < $signed(earliest)) ? cur.hit_time
                                                                  : earliest;
          earliest <= new_first;
          sum_e <= new_sum;
          r = '0;
          r.first_time = new_first;
          r.mean_time = wmean;
          r.total_energy = new_sum;
          r.entry_index = 4'(slot);
          r.entry_count = 5'(used);
          if (hit) begin
            waddr <= slot;
            wdata <= {cur.particle_id, ent_type_old, ne, ent_t_new};
            r.entry_energy = ne;
            r.entry_time = ent_t_new;
          end else if (used < CntW'(TABLE_DEPTH)) begin
            waddr <= slot;
            wdata <= {cur.particle_id, cur.particle_type, 8'd0, cur.energy,
                      cur.hit_time};
            used <= used + CntW'(1);
            r.entry_count = 5'(used + CntW'(1));
            r.was_new = 1'b1;
            r.entry_energy = {8'd0, cur.energy};
            r.entry_time = cur.hit_time;
          end else begin
            // table full: only the totals move
            r.overflow = 1'b1;
            r.entry_index = '0;
          end
          res.data <= r;
          res.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KEWT_ASSERT(a_count_bound, clk, rst, used <= CntW'(TABLE_DEPTH), "fill count over depth")
  `KEWT_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !dep.ready, "ready while busy")
  `KEWT_ASSERT(a_res_flags, clk, rst, res.valid |-> !(res.data.was_new && res.data.overflow), "new and overflow together")
  `KEWT_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (state == S_IDLE && !res.valid), "not idle after reset")
endmodule

// ===== hw/rtl/kewt_blend.sv =====
// Weighted mean update unit: m + trunc((t - m) * e / (w + e)), restoring division.
module kewt_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] mean,
  input  logic [31:0] weight,
  input  logic [31:0] t,
  input  logic [23:0] e,
  output logic        done,
  output logic [31:0] result
);
  import kewt_pkg::*;
  // |delta| < 2^33, times e < 2^24 -> < 2^57
  localparam int NumW = 57;
  localparam int DivW = 33;

  logic [NumW-1:0] quo;
  logic [DivW:0]   rem;
  logic [DivW-1:0] div;
  logic [5:0]      cnt;
  logic            busy;
  logic            neg;
  logic [31:0]     base;
  logic [32:0]     mag;
  logic [32:0]     delta;
  logic [DivW:0]   rem_sh;
  logic [DivW:0]   rem_sub;
  logic [NumW-1:0] prod;
  logic [32:0]     sdelta;

  assign delta = {t[31], t} - {mean[31], mean};
  assign mag = delta[32] ? (~delta + 33'd1) : delta;
  assign prod = {24'd0, mag} * {33'd0, e};
  assign rem_sh = {rem[DivW-1:0], quo[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, div};
  assign sdelta = neg ? (~{quo[32:0]} + 33'd1) : quo[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(NumW);
        div  <= {1'b0, weight} + {9'd0, e};
        quo  <= prod;
        rem  <= '0;
        neg  <= delta[32];
        base <= mean;
      end else if (busy) begin
        if (div == '0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= base;
        end else if (cnt == 6'd0) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= base + sdelta[31:0];
        end else begin
          cnt <= cnt - 6'd1;
          if (!rem_sub[DivW]) begin
            rem <= rem_sub;
            quo <= {quo[NumW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[NumW-2:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
